### sv/assert_macros.svh
// Assertion helpers. Every user module names its clock i_clk and its
// active-low synchronous reset i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/bpa_pkg.sv
package bpa_pkg;

    localparam int NUM_POOLS  = 8;
    localparam int ADDR_BITS  = 32;
    localparam int PERM_POOL  = 3;
    localparam int STAGE_POOL = 2;

    // pool index width
    localparam int PIW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    // aligned value (33b) plus rounded size (33b) never exceeds 34 bits
    localparam int SW  = 34;

    localparam logic PERM_OK  = (PERM_POOL < NUM_POOLS);
    localparam logic STAGE_OK = (STAGE_POOL < NUM_POOLS);
    localparam logic [PIW-1:0] PERM_IDX  = PIW'(PERM_POOL);
    localparam logic [PIW-1:0] STAGE_IDX = PIW'(STAGE_POOL);

    typedef enum logic [2:0] {
        OP_SET_BOUNDS = 3'd0,
        OP_ALLOC      = 3'd1,
        OP_RESIZE     = 3'd2,
        OP_SIZE_LEFT  = 3'd3,
        OP_RESET_POOL = 3'd4,
        OP_CLEAR_POS  = 3'd5
    } t_op;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  pool;
        logic [31:0] size;
        logic [31:0] address;
        logic [31:0] end_address;
    } t_req;

    typedef struct packed {
        logic [31:0] result_address;
        logic        status;
        logic [31:0] bytes_left;
        logic        fell_back;
    } t_rsp;

    typedef struct packed {
        logic load_req;
        logic commit;
    } t_cmd;

    // round up to a multiple of 16, keeping the carry
    function automatic logic [32:0] align16(input logic [31:0] x);
        logic [32:0] s;
        s = {1'b0, x} + 33'd15;
        return {s[32:4], 4'b0000};
    endfunction

endpackage

### sv/bump_pool_allocator.sv
// Bump-pointer pool allocator over a small table of memory pools.
// Input channel (i_in_valid / o_in_ready / i_in_data): one request per
// transfer: op, pool, size, address, end_address.
// Output channel (o_out_valid / i_out_ready / o_out_data): exactly one
// response per request: result_address, status, bytes_left, fell_back.
// Flow: a taken request is registered and the block enters execute; on commit
// the pool table is read, checked and written back and the response is loaded
// into the output register. The input stays closed while in execute, so a new
// request is taken only after the previous one has committed, which waits while
// the output register is full and not draining.
// Output stall: the response sits in an output register. While it waits,
// the next request is still taken and held in execute until the register
// frees up, so nothing is lost or repeated.
// Reset (i_rst_n low, synchronous): all pool bounds, positions and last
// grants go to zero (every pool unusable), the fallback flag clears and
// the output goes invalid. No clearing pass is needed.
module bump_pool_allocator
    import bpa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    t_cmd cmd;

    // sequencing: idle / execute, owns the output valid
    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // pool table, request register, allocate/resize/query logic
    bpa_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_in_data),
        .o_rsp   (o_out_data)
    );

endmodule

### sv/bpa_ctrl.sv
`include "assert_macros.svh"

module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_cmd.load_req  = i_in_valid && o_in_ready;
    // result register must be free or draining this cycle
    assign o_cmd.commit    = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.load_req) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (o_cmd.commit) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `ASSERT_SAME(a_commit_in_exec, o_cmd.commit, r_state == ST_EXEC)
    `ASSERT_SAME(a_no_overlap, o_cmd.load_req, !o_cmd.commit)
    `ASSERT_NEXT(a_commit_sets_valid, o_cmd.commit, r_out_valid)
    `ASSERT_NEXT(a_load_enters_exec, o_cmd.load_req, r_state == ST_EXEC && !o_in_ready)

endmodule

### sv/bpa_dp.sv
module bpa_dp
    import bpa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_req i_req,
    output t_rsp o_rsp
);

    t_req r_req;
    t_rsp r_rsp, n_rsp;

    logic [ADDR_BITS-1:0] r_start [NUM_POOLS];
    logic [ADDR_BITS-1:0] r_end   [NUM_POOLS];
    logic [ADDR_BITS-1:0] r_pos   [NUM_POOLS];
    logic [ADDR_BITS-1:0] r_last  [NUM_POOLS];
    logic [ADDR_BITS-1:0] n_start [NUM_POOLS];
    logic [ADDR_BITS-1:0] n_end   [NUM_POOLS];
    logic [ADDR_BITS-1:0] n_pos   [NUM_POOLS];
    logic [ADDR_BITS-1:0] n_last  [NUM_POOLS];
    logic                 r_flag, n_flag;

    logic                 p_ok;
    logic [PIW-1:0]       p_idx;
    logic [ADDR_BITS-1:0] addr, eaddr;
    logic [ADDR_BITS-1:0] p_start, p_end, p_pos, p_last;
    logic [ADDR_BITS-1:0] m_end, m_pos, m_last;
    logic [32:0]          sz_al;

    // allocate
    logic [32:0]          p_at, m_at;
    logic [SW-1:0]        p_sum, m_sum;
    logic                 p_fit, fb_ok;

    // resize
    logic                 rs_perm, rs_ok;
    logic [PIW-1:0]       rs_idx;
    logic [ADDR_BITS-1:0] rs_pos, rs_last, rs_end;
    logic [SW-1:0]        rs_newpos;

    // size left
    logic                 st_hit, sl_perm, sl_ok;
    logic [ADDR_BITS-1:0] sl_pos, sl_end;
    logic [32:0]          sl_cur;

    assign p_ok    = (32'(r_req.pool) < 32'(NUM_POOLS));
    assign p_idx   = r_req.pool[PIW-1:0];
    assign addr    = r_req.address[ADDR_BITS-1:0];
    assign eaddr   = r_req.end_address[ADDR_BITS-1:0];
    assign p_start = r_start[p_idx];
    assign p_end   = r_end[p_idx];
    assign p_pos   = r_pos[p_idx];
    assign p_last  = r_last[p_idx];
    assign m_end   = r_end[PERM_IDX];
    assign m_pos   = r_pos[PERM_IDX];
    assign m_last  = r_last[PERM_IDX];
    assign sz_al   = align16(r_req.size);

    assign p_at  = align16(32'(p_pos));
    assign m_at  = align16(32'(m_pos));
    assign p_sum = SW'(p_at) + SW'(sz_al);
    assign m_sum = SW'(m_at) + SW'(sz_al);
    assign p_fit = (p_sum <= SW'(p_end));
    assign fb_ok = (32'(r_req.pool) != 32'(PERM_POOL)) && PERM_OK &&
                   (m_pos != '0) && (m_sum <= SW'(m_end));

    // resize follows the last fallback grant into the permanent pool
    assign rs_perm   = r_flag && PERM_OK && (addr == m_last);
    assign rs_idx    = rs_perm ? PERM_IDX : p_idx;
    assign rs_pos    = rs_perm ? m_pos : p_pos;
    assign rs_last   = rs_perm ? m_last : p_last;
    assign rs_end    = rs_perm ? m_end : p_end;
    assign rs_newpos = SW'(rs_last) + SW'(sz_al);
    assign rs_ok     = (rs_perm || p_ok) && (rs_pos != '0) && (addr == rs_last) &&
                       ((rs_newpos <= SW'(rs_pos)) || (rs_newpos <= SW'(rs_end)));

    // after a fallback, or for an empty stage pool, the query goes to the permanent pool
    assign st_hit  = (r_flag ? (PERM_POOL == STAGE_POOL)
                             : (32'(r_req.pool) == 32'(STAGE_POOL))) &&
                     STAGE_OK && (r_start[STAGE_IDX] == r_end[STAGE_IDX]);
    assign sl_perm = r_flag || st_hit;
    assign sl_ok   = sl_perm ? PERM_OK : p_ok;
    assign sl_pos  = sl_perm ? m_pos : p_pos;
    assign sl_end  = sl_perm ? m_end : p_end;
    assign sl_cur  = align16(32'(sl_pos));

    always_comb begin
        n_start = r_start;
        n_end   = r_end;
        n_pos   = r_pos;
        n_last  = r_last;
        n_flag  = r_flag;
        n_rsp   = '0;
        n_rsp.status = 1'b1;
        case (r_req.op)
            OP_SET_BOUNDS: begin
                if (p_ok) begin
                    n_start[p_idx] = addr;
                    n_end[p_idx]   = eaddr;
                    n_pos[p_idx]   = '0;
                    n_rsp.status   = 1'b0;
                end
            end
            OP_ALLOC: begin
                if (p_ok && p_pos != '0) begin
                    if (p_fit) begin
                        n_pos[p_idx]         = p_sum[ADDR_BITS-1:0];
                        n_last[p_idx]        = p_at[ADDR_BITS-1:0];
                        n_rsp.result_address = p_at[31:0];
                        n_rsp.status         = 1'b0;
                    end else if (fb_ok) begin
                        n_pos[PERM_IDX]      = m_sum[ADDR_BITS-1:0];
                        n_last[PERM_IDX]     = m_at[ADDR_BITS-1:0];
                        n_flag               = 1'b1;
                        n_rsp.result_address = m_at[31:0];
                        n_rsp.fell_back      = 1'b1;
                        n_rsp.status         = 1'b0;
                    end
                end
            end
            OP_RESIZE: begin
                if (rs_ok) begin
                    n_pos[rs_idx] = rs_newpos[ADDR_BITS-1:0];
                    n_rsp.status  = 1'b0;
                end
            end
            OP_SIZE_LEFT: begin
                if (sl_ok) begin
                    n_rsp.status = 1'b0;
                    if (sl_cur < 33'(sl_end)) begin
                        n_rsp.bytes_left = 32'(33'(sl_end) - sl_cur);
                    end
                end
            end
            OP_RESET_POOL: begin
                if (p_ok) begin
                    n_last[p_idx] = '0;
                    n_pos[p_idx]  = p_start;
                    n_rsp.status  = 1'b0;
                end
            end
            OP_CLEAR_POS: begin
                if (p_ok) begin
                    n_pos[p_idx] = '0;
                    n_rsp.status = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) r_req <= i_req;
        if (i_cmd.commit)   r_rsp <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '{default: '0};
            r_end   <= '{default: '0};
            r_pos   <= '{default: '0};
            r_last  <= '{default: '0};
            r_flag  <= 1'b0;
        end else if (i_cmd.commit) begin
            r_start <= n_start;
            r_end   <= n_end;
            r_pos   <= n_pos;
            r_last  <= n_last;
            r_flag  <= n_flag;
        end
    end

    assign o_rsp = r_rsp;

endmodule
